// ===== sv/plr_pkg.sv =====
// Shared types and constants for the patterned line rasterizer.
// No dependencies; every other file of the block imports this package.
package plr_pkg;

	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int PITCH_W     = 14;
	localparam int PIXEL_W     = 16;
	localparam int DELTA_W     = 16;

	localparam logic [PITCH_W-1:0]  PITCH_MAX     = 14'd8192;
	localparam logic [PITCH_W-1:0]  PITCH_RESET   = 14'd640;
	localparam logic [PIXEL_W-1:0]  PAT_SOLID     = 16'hffff;
	// Bit position of the pattern MSB (mask 0x8000), used for the first pixel.
	localparam logic [3:0]          PAT_FIRST_BIT = 4'd15;

	localparam logic [2:0] MODE_REPLACE         = 3'd1;
	localparam logic [2:0] MODE_TRANSPARENT     = 3'd2;
	localparam logic [2:0] MODE_XOR             = 3'd3;
	localparam logic [2:0] MODE_REV_TRANSPARENT = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_DRAW_MODE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PITCH      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BASE = 2'd2;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_WRITE  = 2'd1,
		ACT_INVERT = 2'd2
	} action_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pattern;
		logic [PIXEL_W-1:0] fg;
		logic [PIXEL_W-1:0] bg;
	} pen_t;

endpackage

// ===== sv/plr_setup.sv =====
// Line setup: endpoint deltas, Bresenham terms and first pixel address.
// Pure combinational logic; depends on plr_pkg.
module plr_setup import plr_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int ADDR_BITS  = 24
) (
	input  logic [COORD_BITS-1:0]        x_start,
	input  logic [COORD_BITS-1:0]        y_start,
	input  logic [COORD_BITS-1:0]        x_end,
	input  logic [COORD_BITS-1:0]        y_end,
	input  logic [PITCH_W-1:0]           pitch_words,
	input  logic [CFG_DATA_W-1:0]        frame_base,
	output logic [ADDR_BITS-1:0]         start_address,
	output logic signed [COORD_BITS+2:0] err_init,
	output logic signed [COORD_BITS+2:0] inc_straight,
	output logic signed [COORD_BITS+2:0] inc_diagonal,
	output logic [ADDR_BITS-1:0]         step_straight,
	output logic [ADDR_BITS-1:0]         step_diagonal,
	output logic [COORD_BITS-1:0]        count
);

	logic signed [COORD_BITS:0]   dx_raw, dy_raw;
	logic                         x_neg, y_neg, x_major;
	logic [COORD_BITS-1:0]        dx_abs, dy_abs, d_major, d_minor;
	logic [PITCH_W-1:0]           pitch_sat;
	logic signed [DELTA_W-1:0]    xs, ys, sd;
	logic [COORD_BITS+PITCH_W-1:0] row_offset;

	assign dx_raw = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
	assign dy_raw = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
	assign x_neg  = dx_raw[COORD_BITS];
	assign y_neg  = dy_raw[COORD_BITS];
	assign dx_abs = x_neg ? COORD_BITS'(-dx_raw) : COORD_BITS'(dx_raw);
	assign dy_abs = y_neg ? COORD_BITS'(-dy_raw) : COORD_BITS'(dy_raw);

	assign x_major = dx_abs > dy_abs;
	assign d_major = x_major ? dx_abs : dy_abs;
	assign d_minor = x_major ? dy_abs : dx_abs;
	assign count   = d_major;

	assign err_init     = $signed({2'b00, d_minor, 1'b0}) - $signed({3'b000, d_major});
	assign inc_straight = $signed({2'b00, d_minor, 1'b0});
	assign inc_diagonal = $signed({2'b00, d_minor, 1'b0}) - $signed({2'b00, d_major, 1'b0});

	// A pitch above the screen limit is clamped; zero is passed through.
	assign pitch_sat = (pitch_words > PITCH_MAX) ? PITCH_MAX : pitch_words;

	assign xs = x_neg ? -DELTA_W'(signed'(1)) : DELTA_W'(signed'(1));
	assign ys = y_neg ? -$signed({2'b00, pitch_sat}) : $signed({2'b00, pitch_sat});
	assign sd = xs + ys;

	// Sign extension into the address width makes the add wrap correctly.
	assign step_straight = x_major ? ADDR_BITS'(xs) : ADDR_BITS'(ys);
	assign step_diagonal = ADDR_BITS'(sd);

	assign row_offset = {{PITCH_W{1'b0}}, y_start} * {{COORD_BITS{1'b0}}, pitch_sat};
	assign start_address = ADDR_BITS'(frame_base) + ADDR_BITS'(row_offset)
		+ ADDR_BITS'(x_start);

endmodule

// ===== sv/plr_walk.sv =====
// Line walker: Bresenham state registers, one step per advance, and pixel shading.
// Depends on plr_pkg; takes its start terms from plr_setup.
module plr_walk import plr_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int ADDR_BITS  = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         kind,
	input  logic [ADDR_BITS-1:0]         start_address,
	input  logic signed [COORD_BITS+2:0] err_init,
	input  logic signed [COORD_BITS+2:0] inc_straight,
	input  logic signed [COORD_BITS+2:0] inc_diagonal,
	input  logic [ADDR_BITS-1:0]         step_straight,
	input  logic [ADDR_BITS-1:0]         step_diagonal,
	input  logic [COORD_BITS-1:0]        count,
	input  pen_t                         pen,
	input  logic [2:0]                   draw_mode,
	output logic [ADDR_BITS-1:0]         pix_address,
	output logic [PIXEL_W-1:0]           pix_value,
	output action_t                      pix_action,
	output logic                         pix_last
);

	localparam int ERR_W = COORD_BITS + 3;

	logic [ADDR_BITS-1:0]     addr_q, addr_n;
	logic signed [ERR_W-1:0]  err_q, err_n;
	logic signed [ERR_W-1:0]  inc_s_q, inc_s_n, inc_d_q, inc_d_n;
	logic [ADDR_BITS-1:0]     step_s_q, step_s_n, step_d_q, step_d_n;
	logic [COORD_BITS-1:0]    remaining_q, remaining_n;
	logic [3:0]               bit_pos_q, bit_pos_n;
	pen_t                     pen_q, pen_n;
	logic                     active_q, active_n;
	logic                     idle_step;
	logic                     pat_bit;

	always_comb begin
		addr_n      = addr_q;
		err_n       = err_q;
		inc_s_n     = inc_s_q;
		inc_d_n     = inc_d_q;
		step_s_n    = step_s_q;
		step_d_n    = step_d_q;
		remaining_n = remaining_q;
		bit_pos_n   = bit_pos_q;
		pen_n       = pen_q;
		active_n    = active_q;
		idle_step   = 1'b0;
		if (kind == KIND_START) begin
			addr_n      = start_address;
			err_n       = err_init;
			inc_s_n     = inc_straight;
			inc_d_n     = inc_diagonal;
			step_s_n    = step_straight;
			step_d_n    = step_diagonal;
			remaining_n = count;
			bit_pos_n   = PAT_FIRST_BIT;
			pen_n       = pen;
			active_n    = count != '0;
		end else if (active_q) begin
			if (err_q[ERR_W-1]) begin
				err_n  = err_q + inc_s_q;
				addr_n = addr_q + step_s_q;
			end else begin
				err_n  = err_q + inc_d_q;
				addr_n = addr_q + step_d_q;
			end
			bit_pos_n   = bit_pos_q - 4'd1;
			remaining_n = remaining_q - COORD_BITS'(1);
			active_n    = remaining_q != COORD_BITS'(1);
		end else begin
			idle_step = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			err_q       <= '0;
			inc_s_q     <= '0;
			inc_d_q     <= '0;
			step_s_q    <= '0;
			step_d_q    <= '0;
			remaining_q <= '0;
			bit_pos_q   <= PAT_FIRST_BIT;
			pen_q       <= '0;
			active_q    <= 1'b0;
		end else if (advance) begin
			addr_q      <= addr_n;
			err_q       <= err_n;
			inc_s_q     <= inc_s_n;
			inc_d_q     <= inc_d_n;
			step_s_q    <= step_s_n;
			step_d_q    <= step_d_n;
			remaining_q <= remaining_n;
			bit_pos_q   <= bit_pos_n;
			pen_q       <= pen_n;
			active_q    <= active_n;
		end
	end

	assign pat_bit = pen_n.pattern[bit_pos_n];

	always_comb begin
		pix_action = ACT_NONE;
		pix_value  = '0;
		unique case (draw_mode)
			MODE_REPLACE: begin
				pix_action = ACT_WRITE;
				pix_value  = pat_bit ? pen_n.fg : pen_n.bg;
			end
			MODE_TRANSPARENT: begin
				if (pat_bit) begin
					pix_action = ACT_WRITE;
					pix_value  = pen_n.fg;
				end
			end
			MODE_XOR: begin
				if (pat_bit) begin
					pix_action = ACT_INVERT;
				end
			end
			MODE_REV_TRANSPARENT: begin
				// A solid pattern still draws foreground on every pixel.
				if (!pat_bit || pen_n.pattern == PAT_SOLID) begin
					pix_action = ACT_WRITE;
					pix_value  = pen_n.fg;
				end
			end
			default: begin
				pix_action = ACT_NONE;
			end
		endcase
		if (idle_step) begin
			pix_action = ACT_NONE;
			pix_value  = '0;
		end
	end

	assign pix_address = idle_step ? '0 : addr_n;
	assign pix_last    = !active_n;

	a_active_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> remaining_q != '0)
		else $error("active line with no remaining steps");

	a_start_resets_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind == KIND_START |=> bit_pos_q == PAT_FIRST_BIT)
		else $error("line start did not restart the pattern");

endmodule

// ===== sv/patterned_line_rasterizer_unit.sv =====
// Patterned Bresenham line rasterizer. A start item sets up a line and returns its first pixel; each
// step item returns the next pixel, or no action once the line has ended; every item gives exactly one
// result. One item is taken per clock while item_stall is low; it passes through the input register,
// then the result register, with the Bresenham step (one add and compare) and the start address (one
// 12x14 multiply-add) between. Config writes are always ready. Depends on plr_pkg, plr_setup, plr_walk.
module patterned_line_rasterizer_unit import plr_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int ADDR_BITS  = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic                   kind,
	input  logic [COORD_BITS-1:0]  x_start,
	input  logic [COORD_BITS-1:0]  y_start,
	input  logic [COORD_BITS-1:0]  x_end,
	input  logic [COORD_BITS-1:0]  y_end,
	input  logic [PIXEL_W-1:0]     line_pattern,
	input  logic [PIXEL_W-1:0]     fg_pixel,
	input  logic [PIXEL_W-1:0]     bg_pixel,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [ADDR_BITS-1:0]   pixel_address,
	output logic [PIXEL_W-1:0]     pixel_value,
	output logic [1:0]             action,
	output logic                   last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [2:0]            draw_mode_q;
	logic [PITCH_W-1:0]    pitch_q;
	logic [CFG_DATA_W-1:0] frame_base_q;

	logic                  valid_s1;
	logic                  kind_s1;
	logic [COORD_BITS-1:0] x_start_s1, y_start_s1, x_end_s1, y_end_s1;
	pen_t                  pen_s1;

	logic                  item_accept;
	logic                  load;

	logic [ADDR_BITS-1:0]         start_address;
	logic signed [COORD_BITS+2:0] err_init, inc_straight, inc_diagonal;
	logic [ADDR_BITS-1:0]         step_straight, step_diagonal;
	logic [COORD_BITS-1:0]        count;

	logic [ADDR_BITS-1:0] pix_address;
	logic [PIXEL_W-1:0]   pix_value;
	action_t              pix_action;
	logic                 pix_last;

	logic                 result_valid_q;
	logic [ADDR_BITS-1:0] address_q;
	logic [PIXEL_W-1:0]   value_q;
	action_t              action_q;
	logic                 last_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_mode_q  <= MODE_REPLACE;
			pitch_q      <= PITCH_RESET;
			frame_base_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DRAW_MODE:  draw_mode_q  <= cfg_data[2:0];
				REG_PITCH:      pitch_q      <= cfg_data[PITCH_W-1:0];
				REG_FRAME_BASE: frame_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The item in the input register moves on whenever the result register is empty or its result is being taken.
	assign load        = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall  = valid_s1 && !load;
	assign item_accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			kind_s1        <= kind;
			x_start_s1     <= x_start;
			y_start_s1     <= y_start;
			x_end_s1       <= x_end;
			y_end_s1       <= y_end;
			pen_s1.pattern <= line_pattern;
			pen_s1.fg      <= fg_pixel;
			pen_s1.bg      <= bg_pixel;
		end
	end

	plr_setup #(
		.COORD_BITS(COORD_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_setup (
		.x_start      (x_start_s1),
		.y_start      (y_start_s1),
		.x_end        (x_end_s1),
		.y_end        (y_end_s1),
		.pitch_words  (pitch_q),
		.frame_base   (frame_base_q),
		.start_address(start_address),
		.err_init     (err_init),
		.inc_straight (inc_straight),
		.inc_diagonal (inc_diagonal),
		.step_straight(step_straight),
		.step_diagonal(step_diagonal),
		.count        (count)
	);

	plr_walk #(
		.COORD_BITS(COORD_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (load),
		.kind         (kind_s1),
		.start_address(start_address),
		.err_init     (err_init),
		.inc_straight (inc_straight),
		.inc_diagonal (inc_diagonal),
		.step_straight(step_straight),
		.step_diagonal(step_diagonal),
		.count        (count),
		.pen          (pen_s1),
		.draw_mode    (draw_mode_q),
		.pix_address  (pix_address),
		.pix_value    (pix_value),
		.pix_action   (pix_action),
		.pix_last     (pix_last)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			address_q <= pix_address;
			value_q   <= pix_value;
			action_q  <= pix_action;
			last_q    <= pix_last;
		end
	end

	assign result_valid  = result_valid_q;
	assign pixel_address = address_q;
	assign pixel_value   = value_q;
	assign action        = action_q;
	assign last          = last_q;

	a_value_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && action_q != ACT_WRITE |-> value_q == '0)
		else $error("pixel value set without a write action");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_load_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> result_valid_q)
		else $error("result transfer lost after load");

endmodule

// ===== tb/plr_checker.sv =====
// Result checker for the patterned line rasterizer: mirrors the registers, predicts each pixel
// from the accepted items and compares it with the result channel, field by field.
// Depends on plr_pkg.
module plr_checker import plr_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int ADDR_BITS  = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_stall,
	input  logic                   kind,
	input  logic [COORD_BITS-1:0]  x_start,
	input  logic [COORD_BITS-1:0]  y_start,
	input  logic [COORD_BITS-1:0]  x_end,
	input  logic [COORD_BITS-1:0]  y_end,
	input  logic [PIXEL_W-1:0]     line_pattern,
	input  logic [PIXEL_W-1:0]     fg_pixel,
	input  logic [PIXEL_W-1:0]     bg_pixel,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  logic [ADDR_BITS-1:0]   pixel_address,
	input  logic [PIXEL_W-1:0]     pixel_value,
	input  logic [1:0]             action,
	input  logic                   last,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     pending
);

	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic [PIXEL_W-1:0]   value;
		action_t              act;
		logic                 last;
	} pixel_t;

	logic [2:0]            mode_reg;
	logic [PITCH_W-1:0]    pitch_reg;
	logic [CFG_DATA_W-1:0] base_reg;

	logic [ADDR_BITS-1:0] cur_addr;
	int                   err_term;
	int                   inc_str;
	int                   inc_diag;
	int                   step_str;
	int                   step_diag;
	int                   steps_left;
	logic [3:0]           bit_pos;
	pen_t                 pen;
	logic                 active;

	pixel_t expected_pixels[$];

	task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
		$display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
		mismatches++;
	endtask

	// The mode is read per pixel, so a register write in the middle of a line takes effect.
	function automatic pixel_t shade_pixel();
		pixel_t p;
		logic   b;
		b = pen.pattern[bit_pos];
		p.addr = cur_addr;
		p.value = '0;
		p.act = ACT_NONE;
		p.last = !active;
		case (mode_reg)
			MODE_REPLACE: begin
				p.act = ACT_WRITE;
				p.value = b ? pen.fg : pen.bg;
			end
			MODE_TRANSPARENT: begin
				if (b) begin
					p.act = ACT_WRITE;
					p.value = pen.fg;
				end
			end
			MODE_XOR: begin
				if (b)
					p.act = ACT_INVERT;
			end
			MODE_REV_TRANSPARENT: begin
				if (!b || pen.pattern == PAT_SOLID) begin
					p.act = ACT_WRITE;
					p.value = pen.fg;
				end
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic begin_line(input int x1, input int y1, input int x2, input int y2,
			input pen_t p);
		int dx, dy, xs, ys, count, pitch;
		pitch = (pitch_reg > PITCH_MAX) ? int'(PITCH_MAX) : int'(pitch_reg);
		xs = 1;
		ys = pitch;
		dx = x2 - x1;
		dy = y2 - y1;
		if (dx < 0) begin
			dx = -dx;
			xs = -1;
		end
		if (dy < 0) begin
			dy = -dy;
			ys = -ys;
		end
		if (dx > dy) begin
			count = dx;
			step_str = xs;
			inc_str = 2 * dy;
			inc_diag = 2 * dy - 2 * dx;
			err_term = 2 * dy - dx;
		end else begin
			count = dy;
			step_str = ys;
			inc_str = 2 * dx;
			inc_diag = 2 * dx - 2 * dy;
			err_term = 2 * dx - dy;
		end
		step_diag = xs + ys;
		cur_addr = ADDR_BITS'(longint'(base_reg) + longint'(y1) * pitch + x1);
		bit_pos = PAT_FIRST_BIT;
		pen = p;
		steps_left = count;
		active = (count != 0);
	endtask

	task automatic advance_line();
		if (err_term < 0) begin
			err_term += inc_str;
			cur_addr = cur_addr + ADDR_BITS'(step_str);
		end else begin
			err_term += inc_diag;
			cur_addr = cur_addr + ADDR_BITS'(step_diag);
		end
		bit_pos = bit_pos - 4'd1;
		steps_left--;
		active = (steps_left != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		pixel_t idle_px;
		if (!arst_n) begin
			mode_reg = MODE_REPLACE;
			pitch_reg = PITCH_RESET;
			base_reg = '0;
			cur_addr = '0;
			err_term = 0;
			inc_str = 0;
			inc_diag = 0;
			step_str = 0;
			step_diag = 0;
			steps_left = 0;
			bit_pos = PAT_FIRST_BIT;
			pen = '0;
			active = 1'b0;
			expected_pixels.delete();
			pending = 0;
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DRAW_MODE:  mode_reg = cfg_data[2:0];
					REG_PITCH:      pitch_reg = cfg_data[PITCH_W-1:0];
					REG_FRAME_BASE: base_reg = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				if (kind == KIND_START) begin
					begin_line(int'(x_start), int'(y_start), int'(x_end), int'(y_end),
						'{line_pattern, fg_pixel, bg_pixel});
					expected_pixels.push_back(shade_pixel());
				end else if (!active) begin
					idle_px.addr = '0;
					idle_px.value = '0;
					idle_px.act = ACT_NONE;
					idle_px.last = 1'b1;
					expected_pixels.push_back(idle_px);
				end else begin
					advance_line();
					expected_pixels.push_back(shade_pixel());
				end
			end
			if (result_valid && !result_stall) begin
				if (expected_pixels.size() == 0) begin
					report("pixel_address of a result with none pending", '0,
						32'(pixel_address));
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_address !== want.addr)
						report("pixel_address", 32'(want.addr), 32'(pixel_address));
					if (pixel_value !== want.value)
						report("pixel_value", 32'(want.value), 32'(pixel_value));
					if (action !== want.act)
						report("action", 32'(want.act), 32'(action));
					if (last !== want.last)
						report("last", 32'(want.last), 32'(last));
				end
			end
			pending = expected_pixels.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the line rasterizer testbench: clock, reset, register writes and item stimulus.
// Instantiates patterned_line_rasterizer_unit and plr_checker; depends on plr_pkg.
module testbench;
	import plr_pkg::*;

	localparam int COORD_BITS   = 12;
	localparam int ADDR_BITS    = 24;
	localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
	localparam int RANDOM_ITEMS = 1550;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 20;

	// Codes with no meaning in the block, used to check that they are harmless.
	localparam logic [2:0]             MODE_UNDEFINED = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED     = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic                   kind = KIND_START;
	logic [COORD_BITS-1:0]  x_start = '0;
	logic [COORD_BITS-1:0]  y_start = '0;
	logic [COORD_BITS-1:0]  x_end = '0;
	logic [COORD_BITS-1:0]  y_end = '0;
	logic [PIXEL_W-1:0]     line_pattern = '0;
	logic [PIXEL_W-1:0]     fg_pixel = '0;
	logic [PIXEL_W-1:0]     bg_pixel = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [ADDR_BITS-1:0]   pixel_address;
	logic [PIXEL_W-1:0]     pixel_value;
	logic [1:0]             action;
	logic                   last;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int mismatches;
	int pending;
	int items_sent = 0;
	bit quiet = 1'b0;

	patterned_line_rasterizer_unit #(
		.COORD_BITS(COORD_BITS),
		.ADDR_BITS(ADDR_BITS)
	) DUT (.*);

	plr_checker #(
		.COORD_BITS(COORD_BITS),
		.ADDR_BITS(ADDR_BITS)
	) u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return COORD_MAX;
		return $urandom_range(0, COORD_MAX);
	endfunction

	function automatic int near_coord(input int c, input int span);
		int v;
		v = c + $urandom_range(0, 2 * span) - span;
		if (v < 0)
			return 0;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	function automatic logic [PIXEL_W-1:0] pick_pattern();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return PAT_SOLID;
		if (r == 2)
			return '0;
		if (r == 3)
			return 16'h8000;
		return PIXEL_W'($urandom);
	endfunction

	task automatic send_item(input logic k, input int x1, input int y1, input int x2,
			input int y2, input logic [PIXEL_W-1:0] pat,
			input logic [PIXEL_W-1:0] fg, input logic [PIXEL_W-1:0] bg);
		int gap;
		gap = quiet ? 0 : pause_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		x_start <= COORD_BITS'(x1);
		y_start <= COORD_BITS'(y1);
		x_end <= COORD_BITS'(x2);
		y_end <= COORD_BITS'(y2);
		line_pattern <= pat;
		fg_pixel <= fg;
		bg_pixel <= bg;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		items_sent++;
	endtask

	// A step ignores every field but its kind, so those carry noise.
	task automatic send_step();
		send_item(KIND_STEP, int'($urandom_range(0, COORD_MAX)),
			int'($urandom_range(0, COORD_MAX)), int'($urandom_range(0, COORD_MAX)),
			int'($urandom_range(0, COORD_MAX)), PIXEL_W'($urandom),
			PIXEL_W'($urandom), PIXEL_W'($urandom));
	endtask

	// Leaves cfg_valid high so that back-to-back writes need no gap; callers lower it.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic [2:0] mode, input logic [PITCH_W-1:0] pitch,
			input logic [CFG_DATA_W-1:0] base);
		write_reg(REG_DRAW_MODE, CFG_DATA_W'(mode));
		write_reg(REG_PITCH, CFG_DATA_W'(pitch));
		write_reg(REG_FRAME_BASE, base);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every expected pixel has been received.
	task automatic drain_pixels();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	initial begin : stall_gen
		int run;
		run = 0;
		forever begin
			@(posedge clk);
			if (run > 0) begin
				run--;
			end else begin
				result_stall <= !quiet && ($urandom_range(0, 1) == 1);
				run = pause_len();
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	initial begin : stimulus
		int x1, y1, x2, y2, dx, dy, len, steps, r, span, target, phase_end;
		logic [PITCH_W-1:0] pitch;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers still at their reset values: replace mode, pitch 640, base 0.
		send_step();
		send_item(KIND_START, 0, 0, 0, 0, 16'h8000, 16'h0000, 16'hffff);
		send_step();
		send_item(KIND_START, COORD_MAX, COORD_MAX, 0, 0, PAT_SOLID, 16'hffff, 16'hffff);
		send_step();
		send_step();
		// A new start drops the line that is still running.
		send_item(KIND_START, 0, COORD_MAX, COORD_MAX, 0, 16'h0000, 16'h0000, 16'h0000);
		send_step();
		send_item(KIND_START, 10, 5, 3, 9, 16'ha5c3, 16'h1234, 16'hedcb);
		repeat (8) send_step();
		drain_pixels();

		// Saturated pitch on top of the highest base address wraps the address.
		set_config(MODE_XOR, 14'h3fff, 24'hffffff);
		send_item(KIND_START, 0, 1, 1, 0, 16'h4000, 16'h5a5a, 16'ha5a5);
		send_step();
		drain_pixels();

		set_config(MODE_REV_TRANSPARENT, 14'd0, 24'h800000);
		send_item(KIND_START, 0, 0, 1, 2, PAT_SOLID, 16'hbeef, 16'h0f0f);
		send_step();
		send_step();
		drain_pixels();

		set_config(MODE_TRANSPARENT, 14'd1, 24'h000000);
		send_item(KIND_START, 3, 3, 0, 0, 16'h5555, 16'hc3c3, 16'h3c3c);
		send_step();
		drain_pixels();

		set_config(MODE_UNDEFINED, PITCH_MAX, 24'h000123);
		send_item(KIND_START, 0, 0, 2, 0, 16'hffff, 16'h7777, 16'h8888);
		send_step();

		target = items_sent + RANDOM_ITEMS;
		phase_end = items_sent;
		while (items_sent < target) begin
			if (items_sent >= phase_end) begin
				drain_pixels();
				if ($urandom_range(0, 3) != 0)
					write_reg(REG_DRAW_MODE, CFG_DATA_W'($urandom));
				if ($urandom_range(0, 2) != 0) begin
					r = $urandom_range(0, 9);
					case (r)
						0: pitch = '0;
						1: pitch = 14'd1;
						2: pitch = PITCH_MAX;
						3: pitch = '1;
						4, 5, 6: pitch = PITCH_W'($urandom);
						default: pitch = PITCH_W'($urandom_range(1, int'(PITCH_MAX)));
					endcase
					write_reg(REG_PITCH, {10'($urandom), pitch});
				end
				if ($urandom_range(0, 2) != 0) begin
					r = $urandom_range(0, 4);
					if (r == 0)
						write_reg(REG_FRAME_BASE, '0);
					else if (r == 1)
						write_reg(REG_FRAME_BASE, '1);
					else
						write_reg(REG_FRAME_BASE, CFG_DATA_W'($urandom));
				end
				if ($urandom_range(0, 9) == 0)
					write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
				cfg_valid <= 1'b0;
				quiet = ($urandom_range(0, 4) == 0);
				phase_end = items_sent + $urandom_range(40, 200);
			end

			// Mostly short lines walked to the end; some cut short, overrun or huge.
			r = $urandom_range(0, 99);
			x1 = pick_coord();
			y1 = pick_coord();
			if (r < 8) begin
				x2 = pick_coord();
				y2 = pick_coord();
			end else begin
				span = ($urandom_range(0, 3) == 0) ? 40 : 8;
				x2 = near_coord(x1, span);
				y2 = near_coord(y1, span);
			end
			dx = (x2 > x1) ? x2 - x1 : x1 - x2;
			dy = (y2 > y1) ? y2 - y1 : y1 - y2;
			len = (dx > dy) ? dx : dy;
			send_item(KIND_START, x1, y1, x2, y2, pick_pattern(), PIXEL_W'($urandom),
				PIXEL_W'($urandom));
			if (r < 8) begin
				steps = $urandom_range(0, 6);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10)
					steps = len + $urandom_range(1, 3);
				else if (r < 20)
					steps = $urandom_range(0, len);
				else
					steps = len;
			end
			repeat (steps) send_step();
			if ($urandom_range(0, 19) == 0)
				send_step();
		end

		drain_pixels();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/plr_pkg.sv
sv/plr_setup.sv
sv/plr_walk.sv
sv/patterned_line_rasterizer_unit.sv
tb/plr_checker.sv
tb/testbench.sv
